### rtl/bfss_pkg.sv
// Shared types and constants of the single-source shortest path block.
package bfss_pkg;

  localparam int unsigned VERTEX_W = 6;   // vertex id width
  localparam int unsigned NUM_W    = 7;   // vertex count width
  localparam int unsigned DIST_W   = 32;  // distance width
  localparam int unsigned IN_WT_W  = 24;  // weight field width on the stream
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 48;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  localparam logic [DIST_W-1:0] DIST_SAT = {DIST_W{1'b1}};

  // Register index decoded from paddr[2].
  localparam logic REG_START = 1'b0;
  localparam logic REG_NUMV  = 1'b1;

  typedef struct packed {
    logic [VERTEX_W-1:0] start_vertex;
    logic [NUM_W-1:0]    num_vertices;
  } cfg_t;

  typedef struct packed {
    logic idle;  // engine takes a new graph
    logic done;  // last result loaded this cycle
  } eng_status_t;

  // One vertex memory entry.
  typedef struct packed {
    logic [VERTEX_W-1:0] pred;
    logic                unreached;
    logic [DIST_W-1:0]   cost;
  } vtx_t;

  typedef struct packed {
    logic                last;
    logic                reached;
    logic [VERTEX_W-1:0] pred;
    logic [DIST_W-1:0]   cost;
    logic [VERTEX_W-1:0] vid;
  } result_t;

endpackage

### rtl/bellman_ford_single_source.sv
// Top level of the Bellman-Ford single-source shortest path block.
//
// Channel   Dir  Handshake                 Payload
// s_axis    in   tvalid/tready             tdata: origin, target, weight; tlast: last edge
// m_axis    out  tvalid/tready             tdata: vertex, distance, pred, reached; tlast
// apb       in   psel/penable/pwrite       start_vertex @0x0, num_vertices @0x4
//
// Edges load at one request per cycle while the engine is idle, straight into the edge
// memory. A request with tlast starts a run: an init sweep over the vertex memory, then
// N-1 passes (N = effective vertex count; none for one vertex or no edges) over the E
// stored edges, each edge stepping through S_EREAD, S_UREAD and, as needed, S_TREAD and
// S_UPDATE, set by the single read port of the vertex memory (edge, origin and target
// entry read one after another), then S_EMIT_RD and S_EMIT per result. s_axis_tready is
// low from the tlast request until the last result is loaded into the output register;
// m_axis stalls simply hold the emission. Reset is asynchronous and active low;
// it resets the config registers, edge count and control; memories are not cleared.
module bellman_ford_single_source
  import bfss_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned MAX_EDGES    = 1024,
  parameter int unsigned WEIGHT_BITS  = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // stream in
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [5:0] edge_origin, [11:6] edge_target, [35:12] edge_weight, [39:36] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tlast,
  // stream out
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [5:0] vertex_id, [37:6] distance, [43:38] predecessor, [44] reached, [47:45] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned SW  = (WEIGHT_BITS < IN_WT_W) ? WEIGHT_BITS : IN_WT_W;
  localparam int unsigned EW  = 2 * VERTEX_W + SW;
  localparam int unsigned EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned CW  = $clog2(MAX_EDGES + 1);

  cfg_t          cfg_q, cfg_d;
  logic [CW-1:0] edge_count_q, edge_count_d;
  logic          in_req, cfg_wr, edge_we;
  logic [EAW-1:0] edge_raddr;
  logic [EW-1:0]  edge_wdata, edge_rdata;
  eng_status_t   status;
  result_t       res;

  // APB: always ready, register index is paddr[2].
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (paddr[2])
        REG_START: cfg_d.start_vertex = pwdata[VERTEX_W-1:0];
        REG_NUMV:  cfg_d.num_vertices = pwdata[NUM_W-1:0];
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_START: prdata = APB_DATA_W'(cfg_q.start_vertex);
      REG_NUMV:  prdata = APB_DATA_W'(cfg_q.num_vertices);
      default:   prdata = '0;
    endcase
  end

  // Edge load: append while room is left; a full memory drops the edge.
  assign s_axis_tready = status.idle;
  assign in_req        = s_axis_tvalid && s_axis_tready;
  assign edge_we       = in_req && (edge_count_q < CW'(MAX_EDGES));
  assign edge_wdata    = {s_axis_tdata[2*VERTEX_W +: SW],
                          s_axis_tdata[2*VERTEX_W-1:VERTEX_W],
                          s_axis_tdata[VERTEX_W-1:0]};

  always_comb begin
    edge_count_d = edge_count_q;
    if (status.done) begin
      edge_count_d = '0;
    end else if (edge_we) begin
      edge_count_d = edge_count_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q        <= '{start_vertex: '0, num_vertices: NUM_W'(64)};
      edge_count_q <= '0;
    end else begin
      cfg_q        <= cfg_d;
      edge_count_q <= edge_count_d;
    end
  end

  bfss_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_EDGES)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (edge_count_q[EAW-1:0]),
    .wdata_i (edge_wdata),
    .raddr_i (edge_raddr),
    .rdata_o (edge_rdata)
  );

  bfss_engine #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .start_i      (in_req && s_axis_tlast),
    .edge_count_i (edge_count_q),
    .edge_raddr_o (edge_raddr),
    .edge_rdata_i (edge_rdata),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (res),
    .status_o     (status)
  );

  assign m_axis_tdata = {3'b000, res.reached, res.pred, res.cost, res.vid};
  assign m_axis_tlast = res.last;

endmodule

### rtl/bfss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bfss_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/bfss_engine.sv
// Relaxation sequencer: vertex memory init, edge passes and result emission.
module bfss_engine
  import bfss_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned MAX_EDGES    = 1024,
  parameter int unsigned WEIGHT_BITS  = 24,
  localparam int unsigned SW  = (WEIGHT_BITS < IN_WT_W) ? WEIGHT_BITS : IN_WT_W,
  localparam int unsigned EW  = 2 * VERTEX_W + SW,
  localparam int unsigned EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
  localparam int unsigned CW  = $clog2(MAX_EDGES + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_t          cfg_i,
  input  logic          start_i,
  input  logic [CW-1:0] edge_count_i,
  output logic [EAW-1:0] edge_raddr_o,
  input  logic [EW-1:0] edge_rdata_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output result_t       out_data_o,
  output eng_status_t   status_o
);

  localparam int unsigned VAW = $clog2(MAX_VERTICES);
  localparam logic [NUM_W-1:0] MAX_V = NUM_W'(MAX_VERTICES);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_INIT    = 8'b0000_0010,
    S_EREAD   = 8'b0000_0100,
    S_UREAD   = 8'b0000_1000,
    S_TREAD   = 8'b0001_0000,
    S_UPDATE  = 8'b0010_0000,
    S_EMIT_RD = 8'b0100_0000,
    S_EMIT    = 8'b1000_0000
  } state_e;

  state_e              state_q, state_d;
  logic [EAW-1:0]      e_q, e_d;
  logic [VERTEX_W-1:0] pass_q, pass_d;
  logic [VERTEX_W-1:0] v_q, v_d;
  logic [VERTEX_W-1:0] org_q, org_d;
  logic [VERTEX_W-1:0] tgt_q, tgt_d;
  logic [SW-1:0]       w_q, w_d;
  logic [DIST_W-1:0]   sum_q, sum_d;
  logic                ovalid_q, ovalid_d;
  result_t             odata_q, odata_d;

  logic [NUM_W-1:0]    nv;
  logic                start_ok;
  logic                edge_end, pass_end, vtx_end;
  logic [VERTEX_W-1:0] e_org, e_tgt;
  logic [SW-1:0]       e_w;
  logic [DIST_W:0]     sum_wide;
  logic                vwe, load, done;
  logic [VAW-1:0]      vwaddr, vraddr;
  vtx_t                vwdata, vrdata;
  logic [$bits(vtx_t)-1:0] vrdata_raw;

  // Effective vertex count: zero acts as one, clipped to the memory depth.
  always_comb begin
    if (cfg_i.num_vertices == '0) begin
      nv = NUM_W'(1);
    end else if (cfg_i.num_vertices > MAX_V) begin
      nv = MAX_V;
    end else begin
      nv = cfg_i.num_vertices;
    end
  end

  assign start_ok = {1'b0, cfg_i.start_vertex} < nv;
  assign edge_end = (CW'(e_q) + CW'(1)) == edge_count_i;
  assign pass_end = (NUM_W'(pass_q) + NUM_W'(2)) == nv;
  assign vtx_end  = (NUM_W'(v_q) + NUM_W'(1)) == nv;

  assign e_org = edge_rdata_i[VERTEX_W-1:0];
  assign e_tgt = edge_rdata_i[2*VERTEX_W-1:VERTEX_W];
  assign e_w   = edge_rdata_i[2*VERTEX_W +: SW];

  assign vrdata   = vtx_t'(vrdata_raw);
  assign sum_wide = {1'b0, vrdata.cost} + (DIST_W+1)'(w_q);
  assign load     = (state_q == S_EMIT) && (!ovalid_q || out_ready_i);

  always_comb begin
    state_d  = state_q;
    e_d      = e_q;
    pass_d   = pass_q;
    v_d      = v_q;
    org_d    = org_q;
    tgt_d    = tgt_q;
    w_d      = w_q;
    sum_d    = sum_q;
    ovalid_d = ovalid_q;
    odata_d  = odata_q;
    vwe      = 1'b0;
    vwaddr   = v_q[VAW-1:0];
    vwdata   = '{pred: '0, unreached: 1'b1, cost: '0};
    vraddr   = v_q[VAW-1:0];
    done     = 1'b0;

    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          v_d     = '0;
          state_d = S_INIT;
        end
      end
      S_INIT: begin
        vwe = 1'b1;
        vwdata.unreached = !(start_ok && (v_q == cfg_i.start_vertex));
        if (vtx_end) begin
          v_d    = '0;
          e_d    = '0;
          pass_d = '0;
          if (nv == NUM_W'(1) || edge_count_i == '0) begin
            state_d = S_EMIT_RD;
          end else begin
            state_d = S_EREAD;
          end
        end else begin
          v_d = v_q + VERTEX_W'(1);
        end
      end
      S_EREAD: begin
        state_d = S_UREAD;
      end
      S_UREAD: begin
        org_d  = e_org;
        tgt_d  = e_tgt;
        w_d    = e_w;
        vraddr = e_org[VAW-1:0];
        if (({1'b0, e_org} < nv) && ({1'b0, e_tgt} < nv)) begin
          state_d = S_TREAD;
        end else begin
          state_d = S_EREAD;
        end
      end
      S_TREAD: begin
        vraddr = tgt_q[VAW-1:0];
        sum_d  = sum_wide[DIST_W] ? DIST_SAT : sum_wide[DIST_W-1:0];
        if (vrdata.unreached) begin
          state_d = S_EREAD;
        end else begin
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        vwaddr = tgt_q[VAW-1:0];
        vwdata = '{pred: org_q, unreached: 1'b0, cost: sum_q};
        vwe    = vrdata.unreached || (sum_q < vrdata.cost);
        state_d = S_EREAD;
      end
      S_EMIT_RD: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (load) begin
          ovalid_d        = 1'b1;
          odata_d.vid     = v_q;
          odata_d.reached = !vrdata.unreached;
          odata_d.cost    = vrdata.unreached ? DIST_SAT : vrdata.cost;
          odata_d.pred    = vrdata.unreached ? '0 : vrdata.pred;
          odata_d.last    = vtx_end;
          if (vtx_end) begin
            done    = 1'b1;
            state_d = S_IDLE;
          end else begin
            v_d     = v_q + VERTEX_W'(1);
            state_d = S_EMIT_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    // Edge advance shared by the three paths that leave an edge.
    if ((state_q == S_UPDATE) ||
        (state_q == S_TREAD && vrdata.unreached) ||
        (state_q == S_UREAD && state_d == S_EREAD)) begin
      if (edge_end) begin
        e_d = '0;
        if (pass_end) begin
          v_d     = '0;
          state_d = S_EMIT_RD;
        end else begin
          pass_d = pass_q + VERTEX_W'(1);
        end
      end else begin
        e_d = e_q + EAW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
      e_q      <= '0;
      pass_q   <= '0;
      v_q      <= '0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      e_q      <= e_d;
      pass_q   <= pass_d;
      v_q      <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    org_q   <= org_d;
    tgt_q   <= tgt_d;
    w_q     <= w_d;
    sum_q   <= sum_d;
    odata_q <= odata_d;
  end

  bfss_ram #(
    .WIDTH ($bits(vtx_t)),
    .DEPTH (MAX_VERTICES)
  ) u_vtx_ram (
    .clk_i   (clk_i),
    .we_i    (vwe),
    .waddr_i (vwaddr),
    .wdata_i (vwdata),
    .raddr_i (vraddr),
    .rdata_o (vrdata_raw)
  );

  assign edge_raddr_o = e_q;
  assign out_valid_o  = ovalid_q;
  assign out_data_o   = odata_q;
  assign status_o     = '{idle: (state_q == S_IDLE), done: done};

endmodule
